@@ rtl/core/a64ptw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ARM64 page table walker.
// Used by the front, the back and the top level; depends on nothing else.
package a64ptw_pkg;

    // Output address width and the mask applied to the raw table base.
    localparam int unsigned OA_BITS   = 48;
    localparam int unsigned ADDR_W    = 48;
    localparam logic [ADDR_W-1:0] BASE_MASK = 48'hFFFF_FFFF_FFFE;

    // Page shifts per granule.
    localparam logic [4:0] SHIFT_4K  = 5'd12;
    localparam logic [4:0] SHIFT_16K = 5'd14;
    localparam logic [4:0] SHIFT_64K = 5'd16;

    // Descriptor type field codes.
    localparam logic [1:0] DESC_TABLE = 2'b11;
    localparam logic [1:0] DESC_BLOCK = 2'b01;

    // Queue depths.
    localparam int unsigned CQ_DEPTH = 2;
    localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int unsigned CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int unsigned RQ_DEPTH = 2;
    localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef enum logic [1:0] {
        GRANULE_4K_A = 2'd0,
        GRANULE_16K  = 2'd1,
        GRANULE_4K_B = 2'd2,
        GRANULE_64K  = 2'd3
    } granule_t;

    typedef enum logic [1:0] {
        CFG_GRANULE = 2'd0,
        CFG_SIZE    = 2'd1,
        CFG_BASE    = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        RK_READ  = 2'd0,
        RK_LEAF  = 2'd1,
        RK_FAULT = 2'd2
    } result_kind_t;

    // Classification of an accepted item.
    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_TABLE   = 2'd1,
        OP_BLOCK   = 2'd2,
        OP_INVALID = 2'd3
    } op_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] virtual_address;
        logic [63:0] descriptor;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [ADDR_W-1:0] entry_address;
        logic [1:0]        leaf_level;
        logic              is_block;
        logic [ADDR_W-1:0] mapped_address;
    } out_item_t;

    typedef struct packed {
        logic [1:0]        granule_code;
        logic [5:0]        size_offset;
        logic [ADDR_W-1:0] table_base;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] data;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_bus_t;

endpackage

@@ rtl/core/arm64_page_table_walker.sv @@
`timescale 1ns / 1ps
// ARM64 stage-1 page table walker. One item can be taken every clock cycle
// while the command queue is not full: a start item yields the address of
// the first descriptor, and each returned descriptor yields the next read
// address, the leaf or a fault. A taken item is held in the command queue,
// and the walk engine, which steps the walk once per cycle, writes its
// result into the result queue. A full result queue stalls the walk engine,
// and the command queue then fills and raises full. Starts during a walk
// and descriptors with no walk in progress are dropped without a result.
// Configuration writes are always taken and should only be made while the
// block is idle. Depends on a64ptw_pkg, a64ptw_front, a64ptw_back.
module arm64_page_table_walker
    import a64ptw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  in_item_t          item,
    output logic              empty,
    input  logic              pop,
    output out_item_t         result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [ADDR_W-1:0] cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    cmd_bus_t cmd_bus;
    logic     cmd_pop;

    assign cfg_ready = 1'b1;

    // Writes to an index past the last register are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GRANULE: cfg_next.granule_code = cfg_data[1:0];
                CFG_SIZE:    cfg_next.size_offset  = cfg_data[5:0];
                CFG_BASE:    cfg_next.table_base   = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.granule_code <= GRANULE_4K_B;
            cfg_reg.size_offset  <= 6'd16;
            cfg_reg.table_base   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    a64ptw_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .cmd_bus (cmd_bus),
        .cmd_pop (cmd_pop)
    );

    a64ptw_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .cmd_bus (cmd_bus),
        .cmd_pop (cmd_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

@@ rtl/core/a64ptw_front.sv @@
`timescale 1ns / 1ps
// Front end of the walker: accepts items, classifies them and queues them.
// Depends on a64ptw_pkg.
module a64ptw_front
    import a64ptw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output cmd_bus_t cmd_bus,
    input  logic     cmd_pop
);

    cmd_t                cq_mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;
    cmd_t                new_cmd;

    assign full    = (count_reg == CQ_CNT_W'(CQ_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = cmd_pop && (count_reg != '0);

    assign cmd_bus.valid = (count_reg != '0);
    assign cmd_bus.cmd   = cq_mem[rd_ptr_reg];

    // The payload that matters is kept in one field: the address for a start,
    // the descriptor otherwise.
    always_comb
    begin
        new_cmd.data = item.descriptor;
        if (!item.kind)
        begin
            new_cmd.op   = OP_START;
            new_cmd.data = item.virtual_address;
        end
        else
        begin
            unique case (item.descriptor[1:0])
                DESC_TABLE: new_cmd.op = OP_TABLE;
                DESC_BLOCK: new_cmd.op = OP_BLOCK;
                default:    new_cmd.op = OP_INVALID;
            endcase
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cq_mem[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

@@ rtl/core/a64ptw_back.sv @@
`timescale 1ns / 1ps
// Back end of the walker: holds the walk state, steps it for each queued
// command and queues the results. Depends on a64ptw_pkg.
module a64ptw_back
    import a64ptw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  cmd_bus_t  cmd_bus,
    output logic      cmd_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    localparam int unsigned IDX_W = 13;

    function automatic logic [63:0] low_mask(input logic [6:0] n);
        logic [63:0] m;
        if (n >= 7'd64)
        begin
            m = '1;
        end
        else
        begin
            m = (64'd1 << n) - 64'd1;
        end
        return m;
    endfunction

    // Bits lo up to hi-1 set.
    function automatic logic [63:0] field_mask(input logic [6:0] lo, input logic [6:0] hi);
        logic [63:0] m;
        if (lo >= hi)
        begin
            m = '0;
        end
        else
        begin
            m = low_mask(hi) & ~low_mask(lo);
        end
        return m;
    endfunction

    function automatic logic [4:0] shift_of_granule(input logic [1:0] code);
        logic [4:0] s;
        unique case (granule_t'(code))
            GRANULE_16K: s = SHIFT_16K;
            GRANULE_64K: s = SHIFT_64K;
            default:     s = SHIFT_4K;
        endcase
        return s;
    endfunction

    // The level count is the number of index fields that fit in the address
    // bits above the page offset, clamped to one through four.
    function automatic logic [1:0] start_level(input logic [6:0] va_bits,
                                               input logic [3:0] bits);
        logic [6:0] vb4;
        logic [1:0] extra;
        vb4   = (va_bits >= 7'd4) ? va_bits - 7'd4 : 7'd0;
        extra = 2'((vb4 >= 7'(2 * bits)) ? 1 : 0)
              + 2'((vb4 >= 7'(3 * bits)) ? 1 : 0)
              + 2'((vb4 >= 7'(4 * bits)) ? 1 : 0);
        return 2'd3 - extra;
    endfunction

    localparam logic [6:0] OA_LIMIT = 7'(OA_BITS);

    // Walk state
    logic              walk_active_reg, walk_active_next;
    logic [1:0]        walk_level_reg, walk_level_next;
    logic [63:0]       walk_va_reg, walk_va_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;

    // Result queue
    out_item_t           rq_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] rq_wr_reg, rq_wr_next;
    logic [RQ_PTR_W-1:0] rq_rd_reg, rq_rd_next;
    logic [RQ_CNT_W-1:0] rq_count_reg, rq_count_next;
    logic                rq_full;
    logic                rq_push;
    logic                rq_pop;

    logic              step;
    logic [4:0]        shift;
    logic [3:0]        bits;
    logic [6:0]        va_bits;
    logic [1:0]        first_level;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] next_table;
    logic [ADDR_W-1:0] sel_table;
    logic [1:0]        sel_level;
    logic [63:0]       sel_va;
    logic [6:0]        pos;
    logic [63:0]       shifted_va;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] entry;
    logic [6:0]        block_bit;
    logic              emit;
    out_item_t         res;

    assign rq_full = (rq_count_reg == RQ_CNT_W'(RQ_DEPTH));
    assign step    = cmd_bus.valid && !rq_full;
    assign cmd_pop = step;
    assign rq_push = step && emit;
    assign empty   = (rq_count_reg == '0);
    assign rq_pop  = pop && !empty;
    assign result  = rq_mem[rq_rd_reg];

    assign shift       = shift_of_granule(cfg.granule_code);
    assign bits        = 4'(shift - 5'd3);
    assign va_bits     = 7'd64 - {1'b0, cfg.size_offset};
    assign first_level = start_level(va_bits, bits);
    assign base        = cfg.table_base & BASE_MASK & ~ADDR_W'(low_mask({2'b00, shift}));
    assign next_table  = cmd_bus.cmd.data[ADDR_W-1:0]
                       & ADDR_W'(field_mask({2'b00, shift}, OA_LIMIT));

    // One index computation serves both the first read and each table step.
    always_comb
    begin
        if (cmd_bus.cmd.op == OP_START)
        begin
            sel_table = base;
            sel_level = first_level;
            sel_va    = cmd_bus.cmd.data;
        end
        else
        begin
            sel_table = next_table;
            sel_level = walk_level_reg + 2'd1;
            sel_va    = walk_va_reg;
        end
    end

    assign pos        = 7'(bits) * (7'd4 - {5'd0, sel_level}) + 7'd3;
    assign shifted_va = (sel_va & low_mask(va_bits)) >> pos;
    assign idx        = IDX_W'(shifted_va & low_mask({3'b000, bits}));
    assign entry      = sel_table + ADDR_W'({idx, 3'b000});
    assign block_bit  = 7'(bits) * (7'd3 - {5'd0, walk_level_reg}) + {2'b00, shift};

    always_comb
    begin
        walk_active_next = walk_active_reg;
        walk_level_next  = walk_level_reg;
        walk_va_next     = walk_va_reg;
        pend_addr_next   = pend_addr_reg;
        emit             = 1'b0;
        res.result_kind    = RK_READ;
        res.entry_address  = pend_addr_reg;
        res.leaf_level     = walk_level_reg;
        res.is_block       = 1'b0;
        res.mapped_address = '0;

        if (step)
        begin
            if (cmd_bus.cmd.op == OP_START)
            begin
                // A start during a walk is dropped.
                if (!walk_active_reg)
                begin
                    emit              = 1'b1;
                    walk_active_next  = 1'b1;
                    walk_level_next   = sel_level;
                    walk_va_next      = sel_va;
                    pend_addr_next    = entry;
                    res.entry_address = entry;
                    res.leaf_level    = sel_level;
                end
            end
            else if (walk_active_reg)
            begin
                emit = 1'b1;
                priority if (cmd_bus.cmd.op == OP_TABLE && walk_level_reg != 2'd3)
                begin
                    walk_level_next   = sel_level;
                    pend_addr_next    = entry;
                    res.entry_address = entry;
                    res.leaf_level    = sel_level;
                end
                else if (cmd_bus.cmd.op == OP_TABLE)
                begin
                    walk_active_next   = 1'b0;
                    res.result_kind    = RK_LEAF;
                    res.mapped_address = next_table;
                end
                else if (cmd_bus.cmd.op == OP_BLOCK)
                begin
                    walk_active_next   = 1'b0;
                    res.result_kind    = RK_LEAF;
                    res.is_block       = 1'b1;
                    res.mapped_address = cmd_bus.cmd.data[ADDR_W-1:0]
                                       & ADDR_W'(field_mask(block_bit, OA_LIMIT));
                end
                else
                begin
                    walk_active_next = 1'b0;
                    res.result_kind  = RK_FAULT;
                end
            end
        end
    end

    always_comb
    begin
        rq_wr_next    = rq_wr_reg;
        rq_rd_next    = rq_rd_reg;
        rq_count_next = rq_count_reg;
        if (rq_push)
        begin
            rq_wr_next = (rq_wr_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rq_wr_reg + 1'b1;
        end
        if (rq_pop)
        begin
            rq_rd_next = (rq_rd_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rq_rd_reg + 1'b1;
        end
        if (rq_push && !rq_pop)
        begin
            rq_count_next = rq_count_reg + 1'b1;
        end
        else if (rq_pop && !rq_push)
        begin
            rq_count_next = rq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_active_reg <= 1'b0;
            walk_level_reg  <= '0;
            rq_wr_reg       <= '0;
            rq_rd_reg       <= '0;
            rq_count_reg    <= '0;
        end
        else
        begin
            walk_active_reg <= walk_active_next;
            walk_level_reg  <= walk_level_next;
            rq_wr_reg       <= rq_wr_next;
            rq_rd_reg       <= rq_rd_next;
            rq_count_reg    <= rq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_va_reg   <= walk_va_next;
        pend_addr_reg <= pend_addr_next;
        if (rq_push)
        begin
            rq_mem[rq_wr_reg] <= res;
        end
    end

endmodule
